@@ sv/kvq_pkg.sv @@
// ----------------------------------------------------------------------------
// kvq_pkg
// Shared types and constants of the paged key/value cache scatter unit.
// ----------------------------------------------------------------------------
package kvq_pkg;

    localparam logic [2:0] CFG_HEAD_COUNT      = 3'd0;
    localparam logic [2:0] CFG_HEAD_WIDTH      = 3'd1;
    localparam logic [2:0] CFG_SLOTS_PER_BLOCK = 3'd2;
    localparam logic [2:0] CFG_PACK_WIDTH      = 3'd3;
    localparam logic [2:0] CFG_CACHE_FORMAT    = 3'd4;
    localparam logic [2:0] CFG_KEY_SCALE       = 3'd5;
    localparam logic [2:0] CFG_VALUE_SCALE     = 3'd6;

    localparam logic [1:0] FMT_PASS = 2'd0;
    localparam logic [1:0] FMT_E4M3 = 2'd1;
    localparam logic [1:0] FMT_E5M2 = 2'd2;

    localparam logic [10:0] SPB_MAX  = 11'd1024;
    localparam logic [4:0]  PACK_MAX = 5'd16;

    localparam logic [31:0] FP32_ONE     = 32'h3F800000;
    localparam logic [31:0] FP32_QNAN    = 32'h7FC00000;
    localparam logic [31:0] FP32_INF_MAG = 32'h7F800000;

    localparam logic [31:0] E4M3_OVF      = 32'h43F00000;
    localparam logic [31:0] E4M3_MIN_NORM = 32'h3C800000;
    localparam logic [31:0] E4M3_BIAS_ADJ = 32'h3C000000;
    localparam logic [31:0] E4M3_HALF     = 32'h0007FFFF;
    localparam logic [7:0]  E4M3_TINY     = 8'd141;
    localparam logic [31:0] E5M2_OVF      = 32'h47800000;
    localparam logic [31:0] E5M2_MIN_NORM = 32'h38800000;
    localparam logic [31:0] E5M2_BIAS_ADJ = 32'h38000000;
    localparam logic [31:0] E5M2_HALF     = 32'h000FFFFF;
    localparam logic [7:0]  E5M2_TINY     = 8'd134;
    localparam logic [6:0]  FP8_NAN       = 7'h7F;
    localparam logic [6:0]  E5M2_INF      = 7'h7C;

    typedef struct packed {
        logic        drop;
        logic [30:0] blk;
        logic [10:0] off;
        logic [17:0] head;
        logic [10:0] ho;
        logic [10:0] grp;
        logic [4:0]  lane;
    } t_addr_in;

    typedef struct packed {
        logic [8:0]  head_count;
        logic [10:0] head_width;
        logic [10:0] slots_per_block;
        logic [4:0]  pack_width;
        logic [10:0] groups;
    } t_geom;

endpackage

@@ sv/kvq_div_pipe.sv @@
// ----------------------------------------------------------------------------
// kvq_div_pipe
// Restoring divider, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
module kvq_div_pipe #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 4,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [NUM_W];
    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [NUM_W-1:0]  r_quo  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic              v_in;
        logic [NUM_W-1:0]  num_in;
        logic [NUM_W-1:0]  quo_in;
        logic [DEN_W-1:0]  rem_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [NUM_W-1:0]  n_quo;
        logic [DEN_W-1:0]  n_rem;

        if (g == 0) begin : g_head
            assign v_in    = i_valid;
            assign num_in  = i_num;
            assign quo_in  = '0;
            assign rem_in  = '0;
            assign side_in = i_side;
        end else begin : g_tail
            assign v_in    = r_vld[g-1];
            assign num_in  = r_num[g-1];
            assign quo_in  = r_quo[g-1];
            assign rem_in  = r_rem[g-1];
            assign side_in = r_side[g-1];
        end

        always_comb begin
            trial = {rem_in, num_in[NUM_W-1-g]};
            n_quo = quo_in;
            n_rem = trial[DEN_W-1:0];
            if (trial >= {1'b0, i_den}) begin
                n_rem = DEN_W'(trial - {1'b0, i_den});
                n_quo[NUM_W-1-g] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[g]  <= num_in;
            r_quo[g]  <= n_quo;
            r_rem[g]  <= n_rem;
            r_side[g] <= side_in;
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_rem   = r_rem[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

@@ sv/kvq_fp8_quant.sv @@
// ----------------------------------------------------------------------------
// kvq_fp8_quant
// Four-stage fp32 scale multiply and fp8 E4M3/E5M2 encode, or pass-through.
// ----------------------------------------------------------------------------
module kvq_fp8_quant (
    input  logic        i_clk,
    input  logic [31:0] i_word,
    input  logic [31:0] i_scale,
    input  logic [1:0]  i_format,
    output logic [31:0] o_code
);
    import kvq_pkg::*;

    function automatic logic [6:0] f_tiny(input logic [31:0] a, input logic [7:0] base);
        logic [7:0]  e;
        logic [7:0]  s;
        logic [31:0] m;
        logic [31:0] q;
        logic [31:0] rm;
        logic [31:0] half;
        e    = a[30:23];
        m    = {8'd0, 1'b1, a[22:0]};
        s    = base - e;
        q    = m >> s;
        rm   = m & ((32'd1 << s) - 32'd1);
        half = 32'd1 << (s - 8'd1);
        if ((rm > half) || ((rm == half) && q[0])) begin
            q = q + 32'd1;
        end
        if ((e == 8'd0) || (s > 8'd25)) begin
            q = '0;
        end
        return q[6:0];
    endfunction

    // stage 1: unpack, specials, mantissa product
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        r1_sign, r1_nan, r1_inf;
    logic [47:0] r1_prod;
    logic [8:0]  r1_esum;
    logic [31:0] r1_word;

    always_comb begin
        ea     = (i_word[30:23] == 8'd0) ? 8'd1 : i_word[30:23];
        eb     = (i_scale[30:23] == 8'd0) ? 8'd1 : i_scale[30:23];
        ma     = {(i_word[30:23] != 8'd0), i_word[22:0]};
        mb     = {(i_scale[30:23] != 8'd0), i_scale[22:0]};
        a_nan  = (i_word[30:23] == 8'hFF) && (i_word[22:0] != 23'd0);
        b_nan  = (i_scale[30:23] == 8'hFF) && (i_scale[22:0] != 23'd0);
        a_inf  = (i_word[30:23] == 8'hFF) && (i_word[22:0] == 23'd0);
        b_inf  = (i_scale[30:23] == 8'hFF) && (i_scale[22:0] == 23'd0);
        a_zero = (i_word[30:0] == 31'd0);
        b_zero = (i_scale[30:0] == 31'd0);
    end

    always_ff @(posedge i_clk) begin
        r1_sign <= i_word[31] ^ i_scale[31];
        r1_nan  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
        r1_inf  <= a_inf || b_inf;
        r1_prod <= ma * mb;
        r1_esum <= {1'b0, ea} + {1'b0, eb};
        r1_word <= i_word;
    end

    // stage 2: leading zero count
    logic [5:0]  lz;
    logic        r2_sign, r2_nan, r2_inf;
    logic [47:0] r2_prod;
    logic [8:0]  r2_esum;
    logic [5:0]  r2_lz;
    logic [31:0] r2_word;

    always_comb begin
        lz = '0;
        for (int i = 0; i < 48; i++) begin
            if (r1_prod[i]) begin
                lz = 6'(47 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sign <= r1_sign;
        r2_nan  <= r1_nan;
        r2_inf  <= r1_inf;
        r2_prod <= r1_prod;
        r2_esum <= r1_esum;
        r2_lz   <= lz;
        r2_word <= r1_word;
    end

    // stage 3: normalize and round to fp32
    logic [47:0]        pn;
    logic signed [10:0] ex;
    logic [23:0]        mr;
    logic               rnd;
    logic [31:0]        pb;
    logic [31:0]        r3_pb;
    logic [31:0]        r3_word;

    always_comb begin
        pn  = r2_prod << r2_lz;
        rnd = pn[23] && ((pn[22:0] != 23'd0) || pn[24]);
        mr  = {1'b0, pn[46:24]} + {23'd0, rnd};
        ex  = $signed({2'b00, r2_esum}) - $signed({5'd0, r2_lz}) - 11'sd126
              + $signed({10'd0, mr[23]});
        if (r2_nan) begin
            pb = FP32_QNAN;
        end else if (r2_inf || (ex >= 11'sd255)) begin
            pb = {r2_sign, FP32_INF_MAG[30:0]};
        end else if ((r2_prod == 48'd0) || (ex <= 11'sd0)) begin
            pb = {r2_sign, 31'd0};
        end else begin
            pb = {r2_sign, ex[7:0], mr[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r3_pb   <= pb;
        r3_word <= r2_word;
    end

    // stage 4: fp8 encode
    logic [31:0] mag;
    logic [31:0] t;
    logic [6:0]  r;
    logic [7:0]  code;
    logic [7:0]  r4_code;
    logic [31:0] r4_word;

    always_comb begin
        mag = {1'b0, r3_pb[30:0]};
        t   = '0;
        if (i_format == FMT_E4M3) begin
            if (mag >= E4M3_OVF) begin
                r = FP8_NAN;
            end else if (mag < E4M3_MIN_NORM) begin
                r = f_tiny(mag, E4M3_TINY);
            end else begin
                t = mag - E4M3_BIAS_ADJ + E4M3_HALF + {31'd0, mag[20]};
                r = t[26:20];
            end
        end else begin
            if (mag >= E5M2_OVF) begin
                r = (mag > FP32_INF_MAG) ? FP8_NAN : E5M2_INF;
            end else if (mag < E5M2_MIN_NORM) begin
                r = f_tiny(mag, E5M2_TINY);
            end else begin
                t = mag - E5M2_BIAS_ADJ + E5M2_HALF + {31'd0, mag[21]};
                r = t[27:21];
            end
        end
        code = (mag > FP32_INF_MAG) ? {1'b0, FP8_NAN} : {r3_pb[31], r};
    end

    always_ff @(posedge i_clk) begin
        r4_code <= code;
        r4_word <= r3_word;
    end

    assign o_code = ((i_format == FMT_E4M3) || (i_format == FMT_E5M2))
                    ? {24'd0, r4_code} : r4_word;

endmodule

@@ sv/kvq_addr_pipe.sv @@
// ----------------------------------------------------------------------------
// kvq_addr_pipe
// Four-stage multiply-add chain forming the key and value cache indexes.
// ----------------------------------------------------------------------------
module kvq_addr_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  kvq_pkg::t_addr_in i_parts,
    input  kvq_pkg::t_geom    i_geom,
    output logic              o_valid,
    output logic              o_drop,
    output logic [49:0]       o_key_target,
    output logic [49:0]       o_value_target
);
    import kvq_pkg::*;

    logic [3:0]  r_vld;
    logic [3:0]  r_drop;
    logic [49:0] r1_base;
    logic [10:0] r1_off, r1_ho, r1_grp;
    logic [4:0]  r1_lane;
    logic [49:0] r2_t, r2_u;
    logic [10:0] r2_off;
    logic [4:0]  r2_lane;
    logic [49:0] r3_t, r3_u;
    logic [4:0]  r3_lane;
    logic [49:0] r4_k, r4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_drop  <= {r_drop[2:0], i_parts.drop};
        r1_base <= 50'(i_parts.blk * i_geom.head_count) + 50'(i_parts.head);
        r1_off  <= i_parts.off;
        r1_ho   <= i_parts.ho;
        r1_grp  <= i_parts.grp;
        r1_lane <= i_parts.lane;
        r2_t    <= 50'(r1_base * i_geom.groups) + 50'(r1_grp);
        r2_u    <= 50'(r1_base * i_geom.head_width) + 50'(r1_ho);
        r2_off  <= r1_off;
        r2_lane <= r1_lane;
        r3_t    <= 50'(r2_t * i_geom.slots_per_block) + 50'(r2_off);
        r3_u    <= 50'(r2_u * i_geom.slots_per_block) + 50'(r2_off);
        r3_lane <= r2_lane;
        r4_k    <= 50'(r3_t * i_geom.pack_width) + 50'(r3_lane);
        r4_v    <= r3_u;
    end

    assign o_valid        = r_vld[3];
    assign o_drop         = r_drop[3];
    assign o_key_target   = r4_k;
    assign o_value_target = r4_v;

endmodule

@@ sv/paged_kv_cache_scatter_quantize_unit.sv @@
// ----------------------------------------------------------------------------
// paged_kv_cache_scatter_quantize_unit
// Paged key/value cache index generation with optional fp8 quantization.
// ----------------------------------------------------------------------------
// Takes one element per clock: busy stays low and every start beat is taken.
// Each result appears on o_result_valid after its start beat passes 31
// stages of the bit-serial slot / slots_per_block divider, then 4 stages of
// the index multiply chain, which the fp32 scale and fp8 encode run beside.
// Results are strobed for one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module paged_kv_cache_scatter_quantize_unit #(
    parameter int MAX_HEADS      = 256,
    parameter int MAX_HEAD_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [17:0] i_element_index,
    input  logic [31:0] i_slot,
    input  logic [31:0] i_key_word,
    input  logic [31:0] i_value_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_result_valid,
    output logic        o_dropped,
    output logic [49:0] o_key_target,
    output logic [49:0] o_value_target,
    output logic [31:0] o_key_code,
    output logic [31:0] o_value_code
);
    import kvq_pkg::*;

    logic [8:0]  r_head_count;
    logic [10:0] r_head_width;
    logic [10:0] r_slots_per_block;
    logic [4:0]  r_pack_width;
    logic [1:0]  r_cache_format;
    logic [31:0] r_key_scale;
    logic [31:0] r_value_scale;
    logic [8:0]  n_head_count;
    logic [10:0] n_head_width;
    logic [10:0] n_slots_per_block;
    logic [4:0]  n_pack_width;
    logic        cfg_we;
    logic        in_take;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign in_take     = start && !busy;

    always_comb begin
        n_head_count = i_cfg_data[8:0];
        if (i_cfg_data[8:0] == 9'd0) begin
            n_head_count = 9'd1;
        end else if ({23'd0, i_cfg_data[8:0]} > 32'(MAX_HEADS)) begin
            n_head_count = 9'(MAX_HEADS);
        end
        n_head_width = i_cfg_data[10:0];
        if (i_cfg_data[10:0] == 11'd0) begin
            n_head_width = 11'd1;
        end else if ({21'd0, i_cfg_data[10:0]} > 32'(MAX_HEAD_WIDTH)) begin
            n_head_width = 11'(MAX_HEAD_WIDTH);
        end
        n_slots_per_block = i_cfg_data[10:0];
        if (i_cfg_data[10:0] == 11'd0) begin
            n_slots_per_block = 11'd1;
        end else if (i_cfg_data[10:0] > SPB_MAX) begin
            n_slots_per_block = SPB_MAX;
        end
        n_pack_width = i_cfg_data[4:0];
        if (i_cfg_data[4:0] == 5'd0) begin
            n_pack_width = 5'd1;
        end else if (i_cfg_data[4:0] > PACK_MAX) begin
            n_pack_width = PACK_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_count      <= 9'd1;
            r_head_width      <= 11'd64;
            r_slots_per_block <= 11'd16;
            r_pack_width      <= 5'd8;
            r_cache_format    <= FMT_PASS;
            r_key_scale       <= FP32_ONE;
            r_value_scale     <= FP32_ONE;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_HEAD_COUNT:      r_head_count      <= n_head_count;
                CFG_HEAD_WIDTH:      r_head_width      <= n_head_width;
                CFG_SLOTS_PER_BLOCK: r_slots_per_block <= n_slots_per_block;
                CFG_PACK_WIDTH:      r_pack_width      <= n_pack_width;
                CFG_CACHE_FORMAT:    r_cache_format    <= i_cfg_data[1:0];
                CFG_KEY_SCALE:       r_key_scale       <= i_cfg_data;
                CFG_VALUE_SCALE:     r_value_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // group count per head, free running on the static geometry
    logic [10:0] groups;

    kvq_div_pipe #(.NUM_W(11), .DEN_W(5), .SIDE_W(1)) u_grp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (1'b1),
        .i_num   (r_head_width),
        .i_den   (r_pack_width),
        .i_side  (1'b0),
        .o_valid (),
        .o_quo   (groups),
        .o_rem   (),
        .o_side  ()
    );

    // slot split into block and offset
    logic        slot_vld;
    logic [30:0] blk;
    logic [10:0] off;
    logic [64:0] slot_side;

    kvq_div_pipe #(.NUM_W(31), .DEN_W(11), .SIDE_W(65)) u_slot_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_take),
        .i_num   (i_slot[30:0]),
        .i_den   (r_slots_per_block),
        .i_side  ({i_slot[31], i_key_word, i_value_word}),
        .o_valid (slot_vld),
        .o_quo   (blk),
        .o_rem   (off),
        .o_side  (slot_side)
    );

    // element split into head, group and lane
    logic [17:0] head;
    logic [10:0] ho;
    logic [10:0] grp;
    logic [4:0]  lane;
    logic [28:0] ho_side;

    kvq_div_pipe #(.NUM_W(18), .DEN_W(11), .SIDE_W(1)) u_elem_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_take),
        .i_num   (i_element_index),
        .i_den   (r_head_width),
        .i_side  (1'b0),
        .o_valid (),
        .o_quo   (head),
        .o_rem   (ho),
        .o_side  ()
    );

    kvq_div_pipe #(.NUM_W(11), .DEN_W(5), .SIDE_W(29)) u_lane_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (1'b0),
        .i_num   (ho),
        .i_den   (r_pack_width),
        .i_side  ({head, ho}),
        .o_valid (),
        .o_quo   (grp),
        .o_rem   (lane),
        .o_side  (ho_side)
    );

    logic [44:0] r_dly_a;
    logic [44:0] r_dly_b;

    always_ff @(posedge i_clk) begin
        r_dly_a <= {ho_side, grp, lane[4:0]};
        r_dly_b <= r_dly_a;
    end

    t_addr_in parts;
    t_geom    geom;

    always_comb begin
        parts.drop = slot_side[64];
        parts.blk  = blk;
        parts.off  = off;
        parts.head = r_dly_b[44:27];
        parts.ho   = r_dly_b[26:16];
        parts.grp  = r_dly_b[15:5];
        parts.lane = r_dly_b[4:0];
        geom.head_count      = r_head_count;
        geom.head_width      = r_head_width;
        geom.slots_per_block = r_slots_per_block;
        geom.pack_width      = r_pack_width;
        geom.groups          = groups;
    end

    logic        res_drop;
    logic [49:0] key_tgt;
    logic [49:0] value_tgt;
    logic [31:0] key_code;
    logic [31:0] value_code;

    kvq_addr_pipe u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (slot_vld),
        .i_parts        (parts),
        .i_geom         (geom),
        .o_valid        (o_result_valid),
        .o_drop         (res_drop),
        .o_key_target   (key_tgt),
        .o_value_target (value_tgt)
    );

    kvq_fp8_quant u_key_q (
        .i_clk    (i_clk),
        .i_word   (slot_side[63:32]),
        .i_scale  (r_key_scale),
        .i_format (r_cache_format),
        .o_code   (key_code)
    );

    kvq_fp8_quant u_value_q (
        .i_clk    (i_clk),
        .i_word   (slot_side[31:0]),
        .i_scale  (r_value_scale),
        .i_format (r_cache_format),
        .o_code   (value_code)
    );

    assign o_dropped      = res_drop;
    assign o_key_target   = res_drop ? '0 : key_tgt;
    assign o_value_target = res_drop ? '0 : value_tgt;
    assign o_key_code     = res_drop ? '0 : key_code;
    assign o_value_code   = res_drop ? '0 : value_code;

endmodule
